// File: rtl/q24_alu_pkg.sv
package q24_alu_pkg;

  localparam int RES_BITS      = 32;
  localparam int CMD_BITS      = 4;
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_FRAC_BITS = 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  // which unit supplies the final result word
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_MUL   = 2'd1,
    KIND_DIV   = 2'd2
  } kind_t;

endpackage

// File: rtl/q24_8_fixed_point_alu_core.sv
// Signed fixed-point ALU, Q24.8 by default (FRAC_BITS fraction bits in a
// WORD_BITS-bit two's complement word). Raise start with cmd, operand_a and
// operand_b for one cycle to issue a word; busy is always low, so a new word
// may be issued in every cycle. Each word yields exactly one result word,
// shown for a single cycle with done high, in issue order, after passing the
// capture register, stage 1, the divider stages and the output register. The
// divider yields one quotient bit per pipeline stage, and every other
// operation waits alongside it so results never overtake each other. The
// receiver cannot stall; a result must be taken in its cycle. Arithmetic
// wraps silently; divide by zero returns zero with divide_by_zero set.
module q24_8_fixed_point_alu_core #(
  parameter int WORD_BITS = q24_alu_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = q24_alu_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [q24_alu_pkg::CMD_BITS-1:0]    cmd,
  input  logic signed [q24_alu_pkg::RES_BITS-1:0] operand_a,
  input  logic signed [q24_alu_pkg::RES_BITS-1:0] operand_b,
  output logic                                done,
  output logic signed [q24_alu_pkg::RES_BITS-1:0] result,
  output logic                                compare_true,
  output logic                                divide_by_zero
);

  import q24_alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = WORD_BITS + FRAC_BITS;
  // side word: plain result, cmp, kind, neg, dz, product
  localparam int SW = W + 1 + 2 + 1 + 1 + 2 * W;

  // ---- stage 0: capture, narrowed to the working word ----
  logic                v0;
  logic [CMD_BITS-1:0] cmd0;
  logic signed [W-1:0] a0;
  logic signed [W-1:0] b0;

  always_ff @(posedge clk) begin
    cmd0 <= cmd;
    a0   <= operand_a[W-1:0];
    b0   <= operand_b[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
  end

  // ---- stage 1: simple ops, multiply, divider set-up ----
  logic signed [W-1:0] plain_next;
  logic                cmp_next;
  kind_t               kind_next;
  logic [W-1:0]        a_mag;
  logic [W-1:0]        b_mag;

  always_comb begin
    plain_next = '0;
    cmp_next   = 1'b0;
    kind_next  = KIND_PLAIN;
    case (cmd_t'(cmd0))
      CMD_ADD:      plain_next = a0 + b0;
      CMD_SUB:      plain_next = a0 - b0;
      CMD_MUL:      kind_next  = KIND_MUL;
      CMD_DIV:      kind_next  = KIND_DIV;
      CMD_GT:       cmp_next   = a0 > b0;
      CMD_LT:       cmp_next   = a0 < b0;
      CMD_GE:       cmp_next   = a0 >= b0;
      CMD_LE:       cmp_next   = a0 <= b0;
      CMD_EQ:       cmp_next   = a0 == b0;
      CMD_NE:       cmp_next   = a0 != b0;
      CMD_MIN:      plain_next = (a0 < b0) ? a0 : b0;
      CMD_MAX:      plain_next = (a0 > b0) ? a0 : b0;
      CMD_INC:      plain_next = a0 + W'(1);
      CMD_DEC:      plain_next = a0 - W'(1);
      CMD_FROM_INT: plain_next = a0 <<< FRAC_BITS;
      CMD_TO_INT:   plain_next = a0 >>> FRAC_BITS;
      default:      plain_next = '0;
    endcase
  end

  // magnitudes; the most negative word maps to 2^(W-1) unsigned
  assign a_mag = a0[W-1] ? W'(-a0) : a0;
  assign b_mag = b0[W-1] ? W'(-b0) : b0;

  logic                  v1;
  logic [SW-1:0]         side1;
  logic [DW-1:0]         dividend1;
  logic [W-1:0]          divisor1;
  logic signed [2*W-1:0] prod;

  assign prod = (2*W)'(a0) * (2*W)'(b0);

  always_ff @(posedge clk) begin
    side1     <= {plain_next, cmp_next, kind_next, a0[W-1] ^ b0[W-1],
                  b0 == '0, prod};
    dividend1 <= {a_mag, {FRAC_BITS{1'b0}}};
    divisor1  <= b_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  // ---- divider, with side data kept in step ----
  logic          div_valid;
  logic [DW-1:0] quo;
  logic          side_valid;
  logic [SW-1:0] side_d;

  q24_div_pipe #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .dividend  (dividend1),
    .divisor   (divisor1),
    .out_valid (div_valid),
    .quotient  (quo)
  );

  q24_delay #(
    .WIDTH (SW),
    .DEPTH (DW)
  ) u_side (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_data   (side1),
    .out_valid (side_valid),
    .out_data  (side_d)
  );

  // ---- final select ----
  logic signed [W-1:0]   d_plain;
  logic                  d_cmp;
  logic [1:0]            d_kind;
  logic                  d_neg;
  logic                  d_dz;
  logic [2*W-1:0]        d_prod;
  logic [DW-1:0]         quo_signed;
  logic signed [W-1:0]   res_next;
  logic                  dz_next;

  assign {d_plain, d_cmp, d_kind, d_neg, d_dz, d_prod} = side_d;
  assign quo_signed = d_neg ? DW'(-quo) : quo;

  always_comb begin
    dz_next = 1'b0;
    case (kind_t'(d_kind))
      KIND_PLAIN: res_next = d_plain;
      KIND_MUL:   res_next = d_prod[FRAC_BITS+W-1:FRAC_BITS];
      KIND_DIV: begin
        dz_next  = d_dz;
        res_next = d_dz ? '0 : quo_signed[W-1:0];
      end
      default:    res_next = d_plain;
    endcase
  end

  always_ff @(posedge clk) begin
    result         <= RES_BITS'(res_next);
    compare_true   <= d_cmp;
    divide_by_zero <= dz_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_valid & div_valid;
    end
  end

  assign busy = 1'b0;

endmodule

// File: rtl/q24_delay.sv
module q24_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] data [0:DEPTH-1];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    data[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) begin
      data[i] <= data[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule

// File: rtl/q24_div_pipe.sv
module q24_div_pipe #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [WORD_BITS+FRAC_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0]           divisor,
  output logic                           out_valid,
  output logic [WORD_BITS+FRAC_BITS-1:0] quotient
);

  localparam int DW = WORD_BITS + FRAC_BITS;

  // one quotient bit per stage, restoring
  logic [WORD_BITS-1:0] rem [0:DW];
  logic [DW-1:0]        num [0:DW];
  logic [DW-1:0]        quo [0:DW];
  logic [WORD_BITS-1:0] den [0:DW];
  logic [DW:0]          vld;

  assign rem[0] = '0;
  assign num[0] = dividend;
  assign quo[0] = '0;
  assign den[0] = divisor;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;
    logic               ge;

    assign trial = {rem[s], num[s][DW-1]};
    assign diff  = trial - {1'b0, den[s]};
    assign ge    = trial >= {1'b0, den[s]};

    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      num[s+1] <= num[s] << 1;
      quo[s+1] <= {quo[s][DW-2:0], ge};
      den[s+1] <= den[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  assign out_valid = vld[DW];
  assign quotient  = quo[DW];

endmodule

// File: bench/q24_8_fixed_point_alu_core_tb.sv
module q24_8_fixed_point_alu_core_tb;
  import q24_alu_pkg::*;

  // Latency from issue to result, also used to size the drain wait at the end
  localparam int PIPE_LAT    = 43;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic        done;
  logic signed [31:0] result;
  logic        compare_true;
  logic        divide_by_zero;

  // One expected result word: value, compare flag, divide-by-zero flag
  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_word_t;

  alu_word_t alu_expected_q[$];
  int        mismatch_count;
  int        cycle_count;

  q24_8_fixed_point_alu_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .done           (done),
    .result         (result),
    .compare_true   (compare_true),
    .divide_by_zero (divide_by_zero)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Arithmetic behaviour of the ALU, 64-bit intermediates, wrap to 32 bits
  function automatic alu_word_t alu_compute(cmd_t op, logic signed [31:0] a,
                                            logic signed [31:0] b);
    alu_word_t w;
    longint sa;
    longint sb;
    longint prod;
    sa = a;
    sb = b;
    w  = '0;
    case (op)
      CMD_ADD: w.value = sa + sb;
      CMD_SUB: w.value = sa - sb;
      CMD_MUL: begin
        prod    = sa * sb;
        w.value = prod >>> 8;        // arithmetic shift: rounds to minus infinity
      end
      CMD_DIV: begin
        if (sb == 0) w.dz = 1'b1;
        else w.value = (sa * 256) / sb;   // SV divide truncates toward zero
      end
      CMD_GT:       w.cmp = sa > sb;
      CMD_LT:       w.cmp = sa < sb;
      CMD_GE:       w.cmp = sa >= sb;
      CMD_LE:       w.cmp = sa <= sb;
      CMD_EQ:       w.cmp = sa == sb;
      CMD_NE:       w.cmp = sa != sb;
      CMD_MIN:      w.value = (sa < sb) ? a : b;
      CMD_MAX:      w.value = (sa > sb) ? a : b;
      CMD_INC:      w.value = sa + 1;
      CMD_DEC:      w.value = sa - 1;
      CMD_FROM_INT: w.value = sa * 256;
      default:      w.value = sa >>> 8;
    endcase
    return w;
  endfunction

  // Issue one word; busy is tied low but is still honoured.
  // start stays high afterwards so words can follow back to back.
  task automatic issue_word(cmd_t op, logic [31:0] a, logic [31:0] b);
    start     <= 1'b1;
    cmd       <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    alu_expected_q.push_back(alu_compute(op, a, b));
  endtask

  // Sender gap between bursts; a zero gap keeps start high back to back
  int burst_left;
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Operand biased toward the awkward corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
      4: return 32'(int'($urandom_range(0, 2048)) - 1024);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Result checker: done is a strobe, so each result is taken in its cycle
  always @(posedge clk) begin
    alu_word_t want;
    if (!rst && done) begin
      if (alu_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", result);
      end else begin
        want = alu_expected_q.pop_front();
        if (result !== want.value || compare_true !== want.cmp ||
            divide_by_zero !== want.dz) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h cmp %b dz %b, got %h cmp %b dz %b",
                     want.value, want.cmp, want.dz, result, compare_true,
                     divide_by_zero);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every opcode at the extremes, zero divisor, wrap and rounding corners
  task automatic test_directed();
    int i;
    issue_word(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    issue_word(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
    issue_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    issue_word(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    issue_word(CMD_DIV, 32'h0000_0100, 32'h0000_0000);
    issue_word(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    issue_word(CMD_DIV, 32'hFFFF_FF01, 32'h0000_0300);
    issue_word(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_word(CMD_DEC, 32'h8000_0000, 32'h0000_0000);
    issue_word(CMD_FROM_INT, 32'h0080_0000, 32'h0);
    issue_word(CMD_TO_INT, 32'hFFFF_FF01, 32'h0);
    issue_word(CMD_TO_INT, 32'h8000_0000, 32'h0);
    for (i = int'(CMD_GT); i <= int'(CMD_MAX); i++) begin
      issue_word(cmd_t'(i), 32'h8000_0000, 32'h7FFF_FFFF);
      issue_word(cmd_t'(i), 32'h1234_5678, 32'h1234_5678);
    end
  endtask

  // Random words in bursts
  task automatic test_random(int n);
    repeat (n) begin
      sender_gap();
      issue_word(cmd_t'($urandom_range(0, 15)), pick_operand(),
                 ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
    end
  endtask

  // Sender holds off until the pipeline has fully drained
  task automatic test_drain_pause();
    start <= 1'b0;
    while (alu_expected_q.size() != 0) @(posedge clk);
    test_random(50);
  endtask

  initial begin
    int wait_cycles;
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    operand_a      = '0;
    operand_b      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(320);
    test_drain_pause();
    test_random(320);
    start <= 1'b0;
    wait_cycles = 0;
    while (alu_expected_q.size() != 0 && wait_cycles < 10 * PIPE_LAT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_LAT) @(posedge clk);
    if (mismatch_count == 0 && alu_expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
